/* src/kpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

    localparam int KEY_SLOTS      = 16;
    localparam int CODE_W         = 8;
    localparam int TICK_W         = 32;
    localparam int DEB_W          = 8;
    localparam int COUNT_W        = 3;
    localparam int KEYMAP_W       = 64;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_ADDR_W     = 6;
    localparam int CFG_IDX_W      = 3;

    localparam int DEF_MAX_ROWS    = 4;
    localparam int DEF_MAX_COLUMNS = 4;

    localparam logic [COUNT_W-1:0] RST_ROW_COUNT    = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] RST_COLUMN_COUNT = COUNT_W'(4);
    localparam logic [DEB_W-1:0]   RST_DEBOUNCE     = DEB_W'(2);

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } kpd_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT    = 3'd0,
        REG_COLUMN_COUNT = 3'd1,
        REG_DEBOUNCE     = 3'd2,
        REG_KEYMAP_LOW   = 3'd3,
        REG_KEYMAP_HIGH  = 3'd4
    } kpd_reg_t;

    // per-lane control
    typedef struct packed {
        logic             sample;
        logic             clear;
        logic [DEB_W-1:0] debounce;
    } kpd_lane_ctrl_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              found;
    } kpd_result_t;

endpackage

`default_nettype wire

/* src/kpd_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

// One key: edge timer, debounced level and press flag.
module kpd_lane (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire kpd_pkg::kpd_lane_ctrl_t   ctrl,
    input  wire logic                      level,
    input  wire logic [kpd_pkg::TICK_W-1:0] tick,
    output logic                           press
);

    logic                        prev_reg,   prev_next;
    logic                        stable_reg, stable_next;
    logic                        press_reg,  press_next;
    logic [kpd_pkg::TICK_W-1:0]  chg_reg,    chg_next;
    logic [kpd_pkg::TICK_W-1:0]  elapsed;

    always_comb begin
        prev_next   = prev_reg;
        stable_next = stable_reg;
        press_next  = press_reg;
        chg_next    = chg_reg;
        elapsed     = '0;
        if (ctrl.clear) begin
            press_next = 1'b0;
        end
        if (ctrl.sample) begin
            if (level != prev_reg) begin
                chg_next = tick;
            end
            elapsed = tick - chg_next;
            if (elapsed > kpd_pkg::TICK_W'(ctrl.debounce)) begin
                if (!stable_reg && level) begin
                    press_next = 1'b1;
                end
                stable_next = level;
            end
            prev_next = level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= 1'b0;
            stable_reg <= 1'b0;
            press_reg  <= 1'b0;
            chg_reg    <= '0;
        end else begin
            prev_reg   <= prev_next;
            stable_reg <= stable_next;
            press_reg  <= press_next;
            chg_reg    <= chg_next;
        end
    end

    assign press = press_reg;

endmodule

`default_nettype wire

/* src/kpd_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

// Highest-index latched key in use wins; its keymap byte is the code.
module kpd_merge #(
    parameter int LANES = kpd_pkg::KEY_SLOTS
) (
    input  wire logic [LANES-1:0]                          press,
    input  wire logic [LANES-1:0]                          in_use,
    input  wire logic [kpd_pkg::KEY_SLOTS*kpd_pkg::CODE_W-1:0] keymap,
    output kpd_pkg::kpd_result_t                           result
);

    always_comb begin
        result = '0;
        for (int k = 0; k < LANES; k++) begin
            if (press[k] && in_use[k]) begin
                result.code  = keymap[k*kpd_pkg::CODE_W +: kpd_pkg::CODE_W];
                result.found = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* src/matrix_keypad_debouncer_unit.sv */
// A read word's result is registered on m_tdata/m_tuser in the cycle after acceptance
// when the output register is free; otherwise it waits in the skid until that drains.
// Throughput: one word per cycle, sample or read, if the skid is free; all keys are
// debounced in parallel lanes and the read merge is a single priority select, so
// nothing iterates. A two-deep output (register plus skid) keeps s_tready high while
// one result waits. Reset (aresetn low, synchronous): key state, flags and output
`timescale 1ns / 1ps
`default_nettype none

// queue cleared; registers go to rows 4, columns 4, debounce 2, keymaps zero.
module matrix_keypad_debouncer_unit #(
    parameter int MAX_ROWS    = kpd_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = kpd_pkg::DEF_MAX_COLUMNS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // sample / read words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [47:0]                       s_tdata,  // [15:0] key_levels, [47:16] tick_now
    input  wire logic [0:0]                        s_tuser,  // [0] op

    // results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,  // [7:0] key_code
    output logic [0:0]                             m_tuser,  // [0] key_found

    // register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [kpd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [kpd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [kpd_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    // Lanes beyond the matrix size could never be in use.
    localparam int LANES = (MAX_ROWS * MAX_COLUMNS > kpd_pkg::KEY_SLOTS) ?
                           kpd_pkg::KEY_SLOTS : MAX_ROWS * MAX_COLUMNS;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [kpd_pkg::COUNT_W-1:0]  rows_reg;
    logic [kpd_pkg::COUNT_W-1:0]  cols_reg;
    logic [kpd_pkg::DEB_W-1:0]    deb_reg;
    logic [kpd_pkg::KEYMAP_W-1:0] map_lo_reg;
    logic [kpd_pkg::KEYMAP_W-1:0] map_hi_reg;

    logic                         cfg_wr;
    kpd_pkg::kpd_reg_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = kpd_pkg::kpd_reg_t'(paddr[kpd_pkg::CFG_ADDR_W-1 -: kpd_pkg::CFG_IDX_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg   <= kpd_pkg::RST_ROW_COUNT;
            cols_reg   <= kpd_pkg::RST_COLUMN_COUNT;
            deb_reg    <= kpd_pkg::RST_DEBOUNCE;
            map_lo_reg <= '0;
            map_hi_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                kpd_pkg::REG_ROW_COUNT:    rows_reg   <= pwdata[kpd_pkg::COUNT_W-1:0];
                kpd_pkg::REG_COLUMN_COUNT: cols_reg   <= pwdata[kpd_pkg::COUNT_W-1:0];
                kpd_pkg::REG_DEBOUNCE:     deb_reg    <= pwdata[kpd_pkg::DEB_W-1:0];
                kpd_pkg::REG_KEYMAP_LOW:   map_lo_reg <= pwdata[kpd_pkg::KEYMAP_W-1:0];
                kpd_pkg::REG_KEYMAP_HIGH:  map_hi_reg <= pwdata[kpd_pkg::KEYMAP_W-1:0];
                default: ;  // unmapped: dropped
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            kpd_pkg::REG_ROW_COUNT:    prdata = kpd_pkg::CFG_DATA_W'(rows_reg);
            kpd_pkg::REG_COLUMN_COUNT: prdata = kpd_pkg::CFG_DATA_W'(cols_reg);
            kpd_pkg::REG_DEBOUNCE:     prdata = kpd_pkg::CFG_DATA_W'(deb_reg);
            kpd_pkg::REG_KEYMAP_LOW:   prdata = kpd_pkg::CFG_DATA_W'(map_lo_reg);
            kpd_pkg::REG_KEYMAP_HIGH:  prdata = kpd_pkg::CFG_DATA_W'(map_hi_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Keys in use: min(rows, MAX_ROWS) * min(cols, MAX_COLUMNS), capped at 16
    // ------------------------------------------------------------------
    logic [kpd_pkg::COUNT_W-1:0] rows_eff;
    logic [kpd_pkg::COUNT_W-1:0] cols_eff;
    logic [2*kpd_pkg::COUNT_W-1:0] key_prod;
    logic [4:0]                  key_cnt;
    logic [LANES-1:0]            in_use;

    assign rows_eff = (int'(rows_reg) > MAX_ROWS) ? kpd_pkg::COUNT_W'(MAX_ROWS) : rows_reg;
    assign cols_eff = (int'(cols_reg) > MAX_COLUMNS) ?
                      kpd_pkg::COUNT_W'(MAX_COLUMNS) : cols_reg;
    assign key_prod = (2*kpd_pkg::COUNT_W)'(rows_eff) * (2*kpd_pkg::COUNT_W)'(cols_eff);
    assign key_cnt  = (int'(key_prod) > kpd_pkg::KEY_SLOTS) ?
                      5'(kpd_pkg::KEY_SLOTS) : key_prod[4:0];

    // ------------------------------------------------------------------
    // Input word decode
    // ------------------------------------------------------------------
    logic                        s_fire;
    logic                        samp_fire;
    logic                        read_fire;
    logic [kpd_pkg::KEY_SLOTS-1:0] levels;
    logic [kpd_pkg::TICK_W-1:0]  tick_now;

    assign s_fire    = s_tvalid && s_tready;
    assign samp_fire = s_fire && (kpd_pkg::kpd_op_t'(s_tuser[0]) == kpd_pkg::OP_SAMPLE);
    assign read_fire = s_fire && (kpd_pkg::kpd_op_t'(s_tuser[0]) == kpd_pkg::OP_READ);
    assign levels    = s_tdata[kpd_pkg::KEY_SLOTS-1:0];
    assign tick_now  = s_tdata[kpd_pkg::KEY_SLOTS +: kpd_pkg::TICK_W];

    // ------------------------------------------------------------------
    // Key lanes
    // ------------------------------------------------------------------
    logic [LANES-1:0] press_vec;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        kpd_pkg::kpd_lane_ctrl_t lane_ctrl;

        assign in_use[k]          = 5'(k) < key_cnt;
        assign lane_ctrl.sample   = samp_fire && in_use[k];
        assign lane_ctrl.clear    = read_fire;   // read clears every flag
        assign lane_ctrl.debounce = deb_reg;

        kpd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .level   (levels[k]),
            .tick    (tick_now),
            .press   (press_vec[k])
        );
    end

    // ------------------------------------------------------------------
    // Merge of latched flags into one result
    // ------------------------------------------------------------------
    kpd_pkg::kpd_result_t rd_result;

    kpd_merge #(
        .LANES (LANES)
    ) u_merge (
        .press  (press_vec),
        .in_use (in_use),
        .keymap ({map_hi_reg, map_lo_reg}),
        .result (rd_result)
    );

    // ------------------------------------------------------------------
    // Output register plus skid: input stalls only when both are full
    // ------------------------------------------------------------------
    logic                 out_vld_reg;
    logic                 skid_vld_reg;
    kpd_pkg::kpd_result_t out_reg;
    kpd_pkg::kpd_result_t skid_reg;
    logic                 m_fire;

    assign s_tready = !skid_vld_reg;
    assign m_fire   = out_vld_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_fire) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (read_fire) begin
            if (out_vld_reg && !m_tready) begin
                skid_vld_reg <= 1'b1;
            end else begin
                out_vld_reg <= 1'b1;
            end
        end else if (m_fire) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_fire) begin
                out_reg <= skid_reg;
            end
        end else if (read_fire) begin
            if (out_vld_reg && !m_tready) begin
                skid_reg <= rd_result;
            end else begin
                out_reg <= rd_result;
            end
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_reg.code;
    assign m_tuser[0] = out_reg.found;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a word while output is empty");

    a_read_gives_word : assert property (@(posedge aclk) disable iff (!aresetn)
        read_fire |=> m_tvalid)
        else $error("read word produced no result");

    a_read_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        read_fire |=> (press_vec == '0))
        else $error("press flags survive a read");

    a_stall_only_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !$past(m_fire && !read_fire && !skid_vld_reg)))
        else $error("input stalled with output free");

endmodule

`default_nettype wire

/* tb/tb_matrix_keypad_debouncer_unit.sv */
`timescale 1ns / 1ps

module tb_matrix_keypad_debouncer_unit;

    localparam int ROWS_MAX    = kpd_pkg::DEF_MAX_ROWS;
    localparam int COLS_MAX    = kpd_pkg::DEF_MAX_COLUMNS;
    localparam int SPARE_REG   = 5;        // first register index past the map
    localparam int LAST_REG    = 7;
    localparam int SETTLE      = 4;        // cycles after the last result before a write
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int CYCLE_LIMIT = 400000;

    // one scan word as it travels on the input channel
    typedef struct packed {
        kpd_pkg::kpd_op_t op;
        logic [15:0]      levels;
        logic [31:0]      tick;
    } scan_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // [15:0] key_levels, [47:16] tick_now
    logic [0:0]  s_tuser = '0;     // [0] op

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] key_code
    logic [0:0]  m_tuser;          // [0] key_found

    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [kpd_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [kpd_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [kpd_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    matrix_keypad_debouncer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ---------------------------------------------------------------
    // Shadow of the block: register copies and per-key debounce state
    // ---------------------------------------------------------------
    logic [kpd_pkg::COUNT_W-1:0]  cfg_rows     = kpd_pkg::RST_ROW_COUNT;
    logic [kpd_pkg::COUNT_W-1:0]  cfg_cols     = kpd_pkg::RST_COLUMN_COUNT;
    logic [kpd_pkg::DEB_W-1:0]    cfg_debounce = kpd_pkg::RST_DEBOUNCE;
    logic [kpd_pkg::KEYMAP_W-1:0] cfg_map_lo   = '0;
    logic [kpd_pkg::KEYMAP_W-1:0] cfg_map_hi   = '0;

    bit          last_level [kpd_pkg::KEY_SLOTS] = '{default: 1'b0};
    bit          settled    [kpd_pkg::KEY_SLOTS] = '{default: 1'b0};
    bit          press_flag [kpd_pkg::KEY_SLOTS] = '{default: 1'b0};
    logic [31:0] change_at  [kpd_pkg::KEY_SLOTS] = '{default: '0};

    scan_word_t           scan_backlog[$];       // words waiting for the driver
    kpd_pkg::kpd_result_t awaited_reports[$];    // key reports the block still owes us

    int  errors = 0;
    bit  word_taken = 1'b0;             // driver's word went in at the last edge
    bit  hold_request = 1'b0;
    int  cycle_count = 0;

    // ---------------------------------------------------------------
    // Clock, and the run limit
    // ---------------------------------------------------------------
    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // register write as seen by the block; unknown indexes are dropped
    function automatic void apply_register(input int idx, input logic [63:0] value);
        case (idx)
            kpd_pkg::REG_ROW_COUNT:    cfg_rows     = value[kpd_pkg::COUNT_W-1:0];
            kpd_pkg::REG_COLUMN_COUNT: cfg_cols     = value[kpd_pkg::COUNT_W-1:0];
            kpd_pkg::REG_DEBOUNCE:     cfg_debounce = value[kpd_pkg::DEB_W-1:0];
            kpd_pkg::REG_KEYMAP_LOW:   cfg_map_lo   = value;
            kpd_pkg::REG_KEYMAP_HIGH:  cfg_map_hi   = value;
            default: ;
        endcase
    endfunction

    // Advance the keypad by one word. A sample debounces every key in use;
    // a read reports the highest latched key in use and clears all flags.
    function automatic void keypad_advance(input scan_word_t w, output bit has_report,
                                           output kpd_pkg::kpd_result_t rep);
        int          rows;
        int          cols;
        int          in_use;
        bit          lvl;
        logic [31:0] elapsed;
        rows = (cfg_rows > ROWS_MAX) ? ROWS_MAX : cfg_rows;
        cols = (cfg_cols > COLS_MAX) ? COLS_MAX : cfg_cols;
        in_use = rows * cols;
        if (in_use > kpd_pkg::KEY_SLOTS) in_use = kpd_pkg::KEY_SLOTS;
        rep = '0;
        has_report = 1'b0;
        if (w.op == kpd_pkg::OP_SAMPLE) begin
            for (int k = 0; k < in_use; k++) begin
                lvl = w.levels[k];
                if (lvl != last_level[k]) change_at[k] = w.tick;
                elapsed = w.tick - change_at[k];   // wraps at 32 bits
                if (elapsed > 32'(cfg_debounce)) begin
                    if (!settled[k] && lvl) press_flag[k] = 1'b1;
                    settled[k] = lvl;
                end
                last_level[k] = lvl;
            end
        end else begin
            has_report = 1'b1;
            for (int k = 0; k < in_use; k++) begin
                if (press_flag[k]) begin
                    rep.code  = (k < 8) ? cfg_map_lo[k*8 +: 8] : cfg_map_hi[(k-8)*8 +: 8];
                    rep.found = 1'b1;
                end
            end
            press_flag = '{default: 1'b0};
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: bursts of words with random gaps, changes on falling edge
    // ---------------------------------------------------------------
    int         burst_left = 0;
    int         gap_left = 0;
    scan_word_t next_word;

    always @(negedge aclk) begin
        if (!s_tvalid || word_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (scan_backlog.size() > 0) begin
                next_word = scan_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_word.tick, next_word.levels};
                s_tuser  <= next_word.op;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // new burst; a third of them run straight into the next
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall pattern from a randomly redrawn mode; a hold-off
    // request parks m_tready low long enough to back up the input side
    // ---------------------------------------------------------------
    int rx_cycle = 0;
    int rx_mode = 0;
    int hold_left = 0;

    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 48 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_cycle % 5 != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on input acceptance, check on output acceptance
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        scan_word_t           w;
        bit                   has_rep;
        kpd_pkg::kpd_result_t rep;
        kpd_pkg::kpd_result_t want;
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                w.op     = kpd_pkg::kpd_op_t'(s_tuser[0]);
                w.levels = s_tdata[15:0];
                w.tick   = s_tdata[47:16];
                keypad_advance(w, has_rep, rep);
                if (has_rep) awaited_reports.push_back(rep);
            end
            if (m_tvalid && m_tready) begin
                if (awaited_reports.size() == 0) begin
                    report_mismatch("key report with none awaited");
                end else begin
                    want = awaited_reports.pop_front();
                    if (m_tdata !== want.code)
                        report_mismatch($sformatf("key_code %h, want %h", m_tdata, want.code));
                    if (m_tuser[0] !== want.found)
                        report_mismatch($sformatf("key_found %b, want %b",
                                                  m_tuser[0], want.found));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic write_reg(input int idx, input logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= kpd_pkg::CFG_ADDR_W'(idx * 8);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        apply_register(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // registers may only change once the block has drained
    task automatic wait_idle();
        while (scan_backlog.size() != 0 || s_tvalid || awaited_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic push_word(input kpd_pkg::kpd_op_t op, input logic [15:0] levels,
                             input logic [31:0] tick);
        scan_word_t w;
        w.op = op;
        w.levels = levels;
        w.tick = tick;
        scan_backlog.push_back(w);
    endtask

    // Mostly believable scans: keys held for a while, the tick creeping up,
    // now and then a bounce, a long quiet stretch or a tick jump.
    task automatic queue_scan_traffic(input int count, input logic [31:0] start_tick);
        logic [15:0] held;
        logic [15:0] lv;
        logic [31:0] now;
        int          span;
        held = 16'($urandom);
        now  = start_tick;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                // levels and tick are don't-care on a read
                push_word(kpd_pkg::OP_READ, 16'($urandom), $urandom);
            end else begin
                if ($urandom_range(0, 7) == 0) held ^= 16'($urandom);
                span = cfg_debounce / 4 + 2;
                now += $urandom_range(0, span);
                if ($urandom_range(0, 9) == 0) now += 32'(cfg_debounce) + 1;
                if ($urandom_range(0, 29) == 0) now = $urandom;
                lv = held;
                if ($urandom_range(0, 9) == 0) lv ^= 16'($urandom & $urandom);
                push_word(kpd_pkg::OP_SAMPLE, lv, now);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        int rows_set [8] = '{4, 7, 0, 1, 2, 3, 5, 4};
        int cols_set [8] = '{4, 7, 3, 1, 3, 0, 4, 2};
        int deb_set  [8] = '{2, 0, 5, 255, 10, 1, 3, 0};
        logic [31:0] first_tick;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // key 8 0x99, key 9 zero code, key 15 0xFF
        write_reg(kpd_pkg::REG_KEYMAP_LOW,  64'h8877_6655_4433_2211);
        write_reg(kpd_pkg::REG_KEYMAP_HIGH, 64'hFFEE_DDCC_BBAA_0099);
        // writes past the last register must leave everything alone
        write_reg(SPARE_REG, '1);
        write_reg(LAST_REG,  '1);

        // directed, reset geometry 4x4 and debounce 2
        push_word(kpd_pkg::OP_READ,   16'hFFFF, 32'hFFFF_FFFF);   // nothing latched yet
        push_word(kpd_pkg::OP_SAMPLE, 16'hFFFF, 32'd0);           // all keys go down
        push_word(kpd_pkg::OP_SAMPLE, 16'hFFFF, 32'd2);           // exactly the interval
        push_word(kpd_pkg::OP_SAMPLE, 16'hFFFF, 32'd3);           // one past it: all latch
        push_word(kpd_pkg::OP_READ,   16'h0000, 32'd0);           // highest key wins
        push_word(kpd_pkg::OP_READ,   16'h0000, 32'd0);           // flags were cleared
        push_word(kpd_pkg::OP_SAMPLE, 16'h0000, 32'd10);          // release
        push_word(kpd_pkg::OP_SAMPLE, 16'h0000, 32'd13);
        push_word(kpd_pkg::OP_SAMPLE, 16'h0200, 32'd20);          // key with a zero code
        push_word(kpd_pkg::OP_SAMPLE, 16'h0200, 32'd23);
        push_word(kpd_pkg::OP_READ,   16'hFFFF, 32'hFFFF_FFFF);   // found but code zero
        push_word(kpd_pkg::OP_SAMPLE, 16'h0001, 32'hFFFF_FFFE);   // press across tick wrap
        push_word(kpd_pkg::OP_SAMPLE, 16'h0001, 32'd1);
        push_word(kpd_pkg::OP_READ,   16'h0000, 32'd0);
        push_word(kpd_pkg::OP_SAMPLE, 16'h8001, 32'd5);           // one-scan bounce, key 15
        push_word(kpd_pkg::OP_SAMPLE, 16'h0001, 32'd6);
        push_word(kpd_pkg::OP_SAMPLE, 16'h0001, 32'd100);
        push_word(kpd_pkg::OP_READ,   16'h0000, 32'd0);           // bounce must not latch
        wait_idle();

        // random phases over a spread of geometries and intervals,
        // counts above the maximum and zero counts among them
        for (int p = 0; p < 8; p++) begin
            write_reg(kpd_pkg::REG_ROW_COUNT,    64'(rows_set[p]));
            write_reg(kpd_pkg::REG_COLUMN_COUNT, 64'(cols_set[p]));
            write_reg(kpd_pkg::REG_DEBOUNCE,     64'(deb_set[p]));
            write_reg(kpd_pkg::REG_KEYMAP_LOW,   {$urandom, $urandom});
            write_reg(kpd_pkg::REG_KEYMAP_HIGH,  {$urandom, $urandom});
            first_tick = (p == 3) ? 32'hFFFF_FF80 : $urandom;
            if (p == 4) hold_request = 1'b1;   // output stalls long, input backs up
            queue_scan_traffic(66, first_tick);
            wait_idle();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
